>>> design/hptd_pkg.sv
// Shared types and constants for the preorder Huffman tree decoder.
// Used by every module of the block but hptd_ram; depends on nothing else.

package hptd_pkg;

	localparam int MAX_SYMBOLS = 256;
	localparam int INNER_LIMIT = MAX_SYMBOLS - 1;
	localparam int TOKEN_W     = 9;
	localparam int SYM_W       = 8;
	localparam int NODE_W      = 8;
	localparam int LINK_W      = NODE_W + 1;
	localparam int LEAF_CNT_W  = $clog2(MAX_SYMBOLS + 1);
	localparam int DEPTH_W     = $clog2(MAX_SYMBOLS + 1);
	localparam int STACK_AW    = $clog2(MAX_SYMBOLS);

	localparam logic [TOKEN_W-1:0] TOKEN_INNER = TOKEN_W'(256);

	typedef enum logic [1:0] {
		CMD_TOKEN = 2'd0,
		CMD_BIT   = 2'd1,
		CMD_FLUSH = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		KIND_SYMBOL    = 2'd0,
		KIND_LOADED    = 2'd1,
		KIND_MALFORMED = 2'd2,
		KIND_FLUSH     = 2'd3
	} kind_e;

	typedef struct packed {
		logic [1:0]         command;
		logic [TOKEN_W-1:0] tree_token;
		logic               last_token;
		logic               code_bit;
	} request_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [SYM_W-1:0] symbol;
		logic [7:0]       pending_bits;
	} result_t;

	// Link write from the loader; a link holds a leaf flag on top of a node
	// index or, for a leaf, the symbol itself.
	typedef struct packed {
		logic              left_en;
		logic              right_en;
		logic [NODE_W-1:0] addr;
		logic [LINK_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic first;
		logic done;
		logic ok;
	} load_stat_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} walk_res_t;

endpackage

>>> design/hptd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.

module hptd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/hptd_loader.sv
// Tree loader: takes preorder tokens, keeps the node stack and the load
// counters, and issues link writes. Depends on hptd_pkg and hptd_ram.

module hptd_loader (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic [hptd_pkg::TOKEN_W-1:0]   token,
	input  logic                           last,
	output hptd_pkg::link_wr_t             link_wr,
	output hptd_pkg::load_stat_t           stat
);
	import hptd_pkg::*;

	logic [LEAF_CNT_W-1:0] leaf_cnt_q, leaf_cnt_d;
	logic [NODE_W-1:0]     inner_cnt_q, inner_cnt_d;
	logic                  prev_leaf_q, prev_leaf_d;
	logic [NODE_W-1:0]     prev_idx_q, prev_idx_d;
	logic [DEPTH_W-1:0]    depth_q, depth_d;
	logic                  bad_q, bad_d;
	logic [NODE_W-1:0]     top_q, top_d;
	logic [NODE_W-1:0]     second_q, second_d;
	logic                  second_sel_q, second_sel_d;

	logic                  first;
	logic                  node_ok;
	logic                  node_leaf;
	logic [NODE_W-1:0]     node_idx;
	logic                  push;
	logic                  pop;
	logic [NODE_W-1:0]     second_val;
	logic [NODE_W-1:0]     stack_rdata;
	logic                  stack_we;
	logic [STACK_AW-1:0]   stack_waddr;
	logic [STACK_AW-1:0]   stack_raddr;

	// The top of the stack lives in a register; the entries below it sit in
	// the RAM. The entry just below the top is either held in a register or
	// arrives from the RAM read started by the last pop.
	assign second_val = second_sel_q ? second_q : stack_rdata;

	always_comb begin
		first       = !bad_q && (leaf_cnt_q == '0) && (inner_cnt_q == '0);
		leaf_cnt_d  = leaf_cnt_q;
		inner_cnt_d = inner_cnt_q;
		prev_leaf_d = prev_leaf_q;
		prev_idx_d  = prev_idx_q;
		depth_d     = depth_q;
		bad_d       = bad_q;
		node_ok     = 1'b0;
		node_leaf   = 1'b0;
		node_idx    = '0;
		push        = 1'b0;
		pop         = 1'b0;
		link_wr     = '0;
		stat        = '0;

		if (fire && !bad_q) begin
			if (token > TOKEN_INNER) begin
				bad_d = 1'b1;
			end else if (token == TOKEN_INNER) begin
				if (inner_cnt_q >= NODE_W'(INNER_LIMIT)) begin
					bad_d = 1'b1;
				end else begin
					node_ok     = 1'b1;
					node_idx    = inner_cnt_q;
					inner_cnt_d = inner_cnt_q + 1'b1;
				end
			end else begin
				if (leaf_cnt_q >= LEAF_CNT_W'(MAX_SYMBOLS)) begin
					bad_d = 1'b1;
				end else begin
					node_ok    = 1'b1;
					node_leaf  = 1'b1;
					node_idx   = token[NODE_W-1:0];
					leaf_cnt_d = leaf_cnt_q + 1'b1;
				end
			end

			if (node_ok) begin
				if (first) begin
					if (node_leaf) begin
						bad_d = 1'b1;
					end else begin
						prev_leaf_d = node_leaf;
						prev_idx_d  = node_idx;
					end
				end else if (!prev_leaf_q) begin
					if (depth_q >= DEPTH_W'(MAX_SYMBOLS)) begin
						bad_d = 1'b1;
					end else begin
						link_wr.left_en = 1'b1;
						link_wr.addr    = prev_idx_q;
						link_wr.data    = {node_leaf, node_idx};
						push            = 1'b1;
						depth_d         = depth_q + 1'b1;
						prev_leaf_d     = node_leaf;
						prev_idx_d      = node_idx;
					end
				end else begin
					if (depth_q == '0) begin
						bad_d = 1'b1;
					end else begin
						link_wr.right_en = 1'b1;
						link_wr.addr     = top_q;
						link_wr.data     = {node_leaf, node_idx};
						pop              = 1'b1;
						depth_d          = depth_q - 1'b1;
						prev_leaf_d      = node_leaf;
						prev_idx_d       = node_idx;
					end
				end
			end
		end

		stat.first = fire && first;
		if (fire && last) begin
			stat.done   = 1'b1;
			stat.ok     = !bad_d && prev_leaf_d && (depth_d == '0);
			leaf_cnt_d  = '0;
			inner_cnt_d = '0;
			prev_leaf_d = 1'b0;
			prev_idx_d  = '0;
			depth_d     = '0;
			bad_d       = 1'b0;
		end
	end

	always_comb begin
		top_d        = top_q;
		second_d     = second_val;
		second_sel_d = 1'b1;
		stack_we     = 1'b0;
		stack_waddr  = STACK_AW'(depth_q - 1'b1);
		stack_raddr  = STACK_AW'(depth_q - DEPTH_W'(3));
		if (push) begin
			top_d    = prev_idx_q;
			second_d = top_q;
			stack_we = (depth_q != '0);
		end else if (pop) begin
			top_d        = second_val;
			second_sel_d = 1'b0;
		end
	end

	hptd_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_SYMBOLS)
	) u_stack_ram (
		.clk  (clk),
		.we   (stack_we),
		.waddr(stack_waddr),
		.wdata(top_q),
		.raddr(stack_raddr),
		.rdata(stack_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_cnt_q   <= '0;
			inner_cnt_q  <= '0;
			prev_leaf_q  <= 1'b0;
			prev_idx_q   <= '0;
			depth_q      <= '0;
			bad_q        <= 1'b0;
			second_sel_q <= 1'b1;
		end else begin
			leaf_cnt_q   <= leaf_cnt_d;
			inner_cnt_q  <= inner_cnt_d;
			prev_leaf_q  <= prev_leaf_d;
			prev_idx_q   <= prev_idx_d;
			depth_q      <= depth_d;
			bad_q        <= bad_d;
			second_sel_q <= second_sel_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q    <= top_d;
		second_q <= second_d;
	end

endmodule

>>> design/hptd_walker.sv
// Tree walker: follows code bits from the root and reports symbols and
// flushes. Depends on hptd_pkg; reads the link RAMs held at the top level.

module hptd_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire_bit,
	input  logic                          fire_flush,
	input  logic                          code_bit,
	input  hptd_pkg::load_stat_t          stat,
	input  hptd_pkg::link_wr_t            link_wr,
	input  logic [hptd_pkg::LINK_W-1:0]   left_rdata,
	input  logic [hptd_pkg::LINK_W-1:0]   right_rdata,
	output logic [hptd_pkg::NODE_W-1:0]   raddr,
	output hptd_pkg::walk_res_t           res
);
	import hptd_pkg::*;

	logic [NODE_W-1:0] walk_q, walk_d;
	logic [7:0]        bits_q, bits_d;
	logic              ready_q, ready_d;
	logic              left_wr_q, right_wr_q;
	logic [NODE_W-1:0] wr_addr_q;
	logic [LINK_W-1:0] wr_data_q;
	logic [LINK_W-1:0] left_val, right_val, child;

	// The link RAMs are read at the next walk node every cycle. A link written
	// at the same edge is not in that read, so it is taken from the last write.
	always_comb begin
		left_val  = left_rdata;
		right_val = right_rdata;
		if (left_wr_q && (wr_addr_q == walk_q)) begin
			left_val = wr_data_q;
		end
		if (right_wr_q && (wr_addr_q == walk_q)) begin
			right_val = wr_data_q;
		end
		child = code_bit ? right_val : left_val;
	end

	always_comb begin
		walk_d  = walk_q;
		bits_d  = bits_q;
		ready_d = ready_q;
		res     = '0;

		if (stat.done) begin
			ready_d = stat.ok;
			walk_d  = '0;
			bits_d  = '0;
		end else if (stat.first) begin
			ready_d = 1'b0;
		end

		if (fire_bit && ready_q) begin
			bits_d = bits_q + 1'b1;
			if (child[LINK_W-1]) begin
				res.valid       = 1'b1;
				res.data.kind   = KIND_SYMBOL;
				res.data.symbol = child[SYM_W-1:0];
				walk_d          = '0;
				bits_d          = '0;
			end else begin
				walk_d = child[NODE_W-1:0];
			end
		end

		if (fire_flush) begin
			res.valid             = 1'b1;
			res.data.kind         = KIND_FLUSH;
			res.data.pending_bits = ready_q ? bits_q : 8'd0;
			walk_d                = '0;
			bits_d                = '0;
		end
	end

	assign raddr = walk_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q     <= '0;
			bits_q     <= '0;
			ready_q    <= 1'b0;
			left_wr_q  <= 1'b0;
			right_wr_q <= 1'b0;
		end else begin
			walk_q     <= walk_d;
			bits_q     <= bits_d;
			ready_q    <= ready_d;
			left_wr_q  <= link_wr.left_en;
			right_wr_q <= link_wr.right_en;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= link_wr.addr;
		wr_data_q <= link_wr.data;
	end

endmodule

>>> design/huffman_preorder_tree_decoder.sv
// Huffman decoder whose tree is loaded as a preorder token list.
// Usage:
//   Requests enter on request_valid / request_stall / request. A request is a
//   tree token, a code bit or a flush. Results leave on result_valid /
//   result_stall / result: a decoded symbol, a tree loaded or malformed
//   report at the last token of a list, or a flush report with the count of
//   bits that belong to an unfinished symbol.
//   Path: a request taken at one edge waits in the input register, and its
//   result is registered in the result register, from which the result
//   port is driven.
//   Throughput: one request per cycle unless stalled, code bits included; the
//   walk reads both child links of the current node from registered-read RAMs,
//   so the next node's links are ready by the time the next bit arrives.
//   Reset: no tree is ready, the walk sits at the root and the load state is
//   clear. The link and stack RAMs are not cleared; a tree only reads links
//   its own list wrote.
//   Stall: while result_stall holds a result in the result register, the
//   input register still takes one more request; after that request_stall
//   rises until the result is taken.
// Depends on hptd_pkg, hptd_ram, hptd_loader and hptd_walker.

module huffman_preorder_tree_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                request_valid,
	output logic                request_stall,
	input  hptd_pkg::request_t  request,
	output logic                result_valid,
	input  logic                result_stall,
	output hptd_pkg::result_t   result
);
	import hptd_pkg::*;

	request_t   req_s1;
	logic       req_valid_s1;
	result_t    res_s2;
	logic       res_valid_s2;

	logic       advance;
	logic       fire;
	logic       fire_token, fire_bit, fire_flush;
	link_wr_t   link_wr;
	load_stat_t stat;
	walk_res_t  walk_res;
	logic [NODE_W-1:0] link_raddr;
	logic [LINK_W-1:0] left_rdata, right_rdata;
	logic       out_valid;
	result_t    out_data;

	assign advance       = !(res_valid_s2 && result_stall);
	assign request_stall = req_valid_s1 && !advance;
	assign fire          = req_valid_s1 && advance;

	always_comb begin
		fire_token = 1'b0;
		fire_bit   = 1'b0;
		fire_flush = 1'b0;
		unique case (req_s1.command)
			CMD_TOKEN: fire_token = fire;
			CMD_BIT:   fire_bit   = fire;
			CMD_FLUSH: fire_flush = fire;
			default: begin
			end
		endcase
	end

	hptd_loader u_loader (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_token),
		.token  (req_s1.tree_token),
		.last   (req_s1.last_token),
		.link_wr(link_wr),
		.stat   (stat)
	);

	hptd_ram #(
		.WIDTH(LINK_W),
		.DEPTH(INNER_LIMIT)
	) u_left_ram (
		.clk  (clk),
		.we   (link_wr.left_en),
		.waddr(link_wr.addr),
		.wdata(link_wr.data),
		.raddr(link_raddr),
		.rdata(left_rdata)
	);

	hptd_ram #(
		.WIDTH(LINK_W),
		.DEPTH(INNER_LIMIT)
	) u_right_ram (
		.clk  (clk),
		.we   (link_wr.right_en),
		.waddr(link_wr.addr),
		.wdata(link_wr.data),
		.raddr(link_raddr),
		.rdata(right_rdata)
	);

	hptd_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire_bit   (fire_bit),
		.fire_flush (fire_flush),
		.code_bit   (req_s1.code_bit),
		.stat       (stat),
		.link_wr    (link_wr),
		.left_rdata (left_rdata),
		.right_rdata(right_rdata),
		.raddr      (link_raddr),
		.res        (walk_res)
	);

	always_comb begin
		out_valid = walk_res.valid;
		out_data  = walk_res.data;
		if (stat.done) begin
			out_valid     = 1'b1;
			out_data      = '0;
			out_data.kind = stat.ok ? KIND_LOADED : KIND_MALFORMED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (!request_stall) begin
				req_valid_s1 <= request_valid;
			end
			if (advance) begin
				res_valid_s2 <= fire && out_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (request_valid && !request_stall) begin
			req_s1 <= request;
		end
		if (fire && out_valid) begin
			res_s2 <= out_data;
		end
	end

	assign result_valid = res_valid_s2;
	assign result       = res_s2;

endmodule
